### sv/rfb_pkg.sv
// Shared types and constants for the recursive frame blur block.
// Used by rfb_cfg, rfb_ram users and recursive_frame_blur_top.
`default_nettype none
package rfb_pkg;

	localparam int SAMPLE_BITS             = 8;
	localparam int DEFAULT_MAX_LUMA_PIXELS = 1048576;

	localparam int PLANE_BITS    = 2;
	localparam int INDEX_BITS    = 20;
	localparam int PERIOD_BITS   = 10;
	localparam int DIM_BITS      = 12;
	localparam int LEN_BITS      = 2 * DIM_BITS;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 12;
	localparam int IN_DATA_BITS  = 32;

	// plane codes carried on tuser
	localparam logic [PLANE_BITS-1:0] PLANE_LUMA = 2'd0;
	localparam logic [PLANE_BITS-1:0] PLANE_CB   = 2'd1;
	localparam logic [PLANE_BITS-1:0] PLANE_CR   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_BLUR_PERIOD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LUMA_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LUMA_HEIGHT = 2'd2;

	localparam logic [PERIOD_BITS-1:0] RESET_BLUR_PERIOD = 10'd15;
	localparam logic [DIM_BITS-1:0]    RESET_LUMA_WIDTH  = 12'd352;
	localparam logic [DIM_BITS-1:0]    RESET_LUMA_HEIGHT = 12'd288;
	localparam logic [LEN_BITS-1:0]    RESET_LUMA_LEN    = 24'd101376;

	typedef struct packed {
		logic [PERIOD_BITS-1:0] blur_period;
		logic [LEN_BITS-1:0]    luma_len;
		logic [LEN_BITS-1:0]    chroma_len;
	} cfg_t;

endpackage
`default_nettype wire

### sv/rfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none
module rfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

### sv/rfb_cfg.sv
// Configuration registers and derived plane sizes for the frame blur.
// Depends on rfb_pkg.
`default_nettype none
module rfb_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [rfb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [rfb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output rfb_pkg::cfg_t                           cfg
);
	import rfb_pkg::*;

	logic [PERIOD_BITS-1:0] period_q;
	logic [DIM_BITS-1:0]    width_q;
	logic [DIM_BITS-1:0]    height_q;
	logic [LEN_BITS-1:0]    len_q;
	logic [DIM_BITS-1:0]    width_n;
	logic [DIM_BITS-1:0]    height_n;

	// take the size of the write into the product in the same edge
	always_comb begin
		width_n  = (cfg_index == REG_LUMA_WIDTH)  ? cfg_wdata : width_q;
		height_n = (cfg_index == REG_LUMA_HEIGHT) ? cfg_wdata : height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESET_BLUR_PERIOD;
			width_q  <= RESET_LUMA_WIDTH;
			height_q <= RESET_LUMA_HEIGHT;
			len_q    <= RESET_LUMA_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLUR_PERIOD: period_q <= cfg_wdata[PERIOD_BITS-1:0];
				REG_LUMA_WIDTH:  width_q  <= cfg_wdata;
				REG_LUMA_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
			len_q <= LEN_BITS'(width_n) * LEN_BITS'(height_n);
		end
	end

	assign cfg.blur_period = period_q;
	assign cfg.luma_len    = len_q;
	assign cfg.chroma_len  = len_q >> 2;

endmodule
`default_nettype wire

### sv/recursive_frame_blur_top.sv
// Recursive frame averaging over a 4:2:0 sample stream; one frame store per plane.
// A sample is read from its plane store into stage 1, then averaged and
// written back as it moves to the output register. Throughput: one sample per
// cycle unless the master stalls, set by the store read and write-back forwarding.
// Reset clears the pipeline, the frame phase and the registers (period 15, 352x288);
// store contents stay undefined until written, with no clearing pass.
`default_nettype none
module recursive_frame_blur_top #(
	parameter int MAX_LUMA_PIXELS = rfb_pkg::DEFAULT_MAX_LUMA_PIXELS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [rfb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [rfb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [rfb_pkg::IN_DATA_BITS-1:0]   s_tdata,  // sample_value, pixel_index
	input  wire logic [rfb_pkg::PLANE_BITS-1:0]     s_tuser,  // plane
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [rfb_pkg::SAMPLE_BITS-1:0]    m_tdata,  // blurred_value
	output logic                                    m_tlast,  // frame_done
	output logic                                    m_tuser   // index_error
);
	import rfb_pkg::*;

	localparam int CHROMA_DEPTH = MAX_LUMA_PIXELS / 4;
	localparam int LA           = $clog2(MAX_LUMA_PIXELS);
	localparam int CA           = $clog2(CHROMA_DEPTH);

	cfg_t cfg;

	rfb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input decode
	logic [SAMPLE_BITS-1:0] sample_in;
	logic [INDEX_BITS-1:0]  idx_in;
	logic [PLANE_BITS-1:0]  plane_in;
	logic [LEN_BITS-1:0]    idx_ext;
	logic [LEN_BITS-1:0]    last_idx;
	logic                   in_range;
	logic                   done_in;
	logic                   accept;

	assign sample_in = s_tdata[SAMPLE_BITS-1:0];
	assign idx_in    = s_tdata[SAMPLE_BITS+INDEX_BITS-1:SAMPLE_BITS];
	assign plane_in  = s_tuser;
	assign idx_ext   = LEN_BITS'(idx_in);
	assign last_idx  = (cfg.chroma_len == '0) ? '0 : cfg.chroma_len - 1'b1;

	always_comb begin
		case (plane_in)
			PLANE_LUMA: in_range = (idx_ext < cfg.luma_len) &&
			                       (32'(idx_in) < 32'(MAX_LUMA_PIXELS));
			PLANE_CB, PLANE_CR: in_range = (idx_ext < cfg.chroma_len) &&
			                       (32'(idx_in) < 32'(CHROMA_DEPTH));
			default: in_range = 1'b0;
		endcase
	end

	assign done_in = (plane_in == PLANE_CR) && (idx_ext == last_idx);

	// stage 1 registers: store read in flight
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [PLANE_BITS-1:0]  plane_s1;
	logic [INDEX_BITS-1:0]  idx_s1;
	logic                   we_s1;
	logic                   done_s1;
	logic                   fwd_s1;
	logic [SAMPLE_BITS-1:0] fwd_data_s1;

	logic                   adv_s1;
	logic                   wr_s1;
	logic                   fwd_n;
	logic [SAMPLE_BITS-1:0] stored_s1;
	logic [SAMPLE_BITS:0]   sum_s1;
	logic [SAMPLE_BITS-1:0] result_s1;

	logic [PERIOD_BITS-1:0] phase_q;
	logic [PERIOD_BITS-1:0] phase_inc;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic                   out_last_q;
	logic                   out_err_q;

	logic [SAMPLE_BITS-1:0] luma_rdata;
	logic [SAMPLE_BITS-1:0] cb_rdata;
	logic [SAMPLE_BITS-1:0] cr_rdata;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;
	assign wr_s1    = adv_s1 && we_s1;

	// the store read returns old data when the item ahead writes the same entry
	assign fwd_n = wr_s1 && (plane_s1 == plane_in) && (idx_s1 == idx_in);

	always_comb begin
		case (plane_s1)
			PLANE_LUMA: stored_s1 = luma_rdata;
			PLANE_CB:   stored_s1 = cb_rdata;
			default:    stored_s1 = cr_rdata;
		endcase
		if (fwd_s1) begin
			stored_s1 = fwd_data_s1;
		end
		sum_s1 = {1'b0, sample_s1} + {1'b0, stored_s1};
		if (we_s1 && (phase_q != '0)) begin
			result_s1 = sum_s1[SAMPLE_BITS:1];
		end else begin
			result_s1 = sample_s1;
		end
	end

	assign phase_inc = phase_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= sample_in;
			plane_s1    <= plane_in;
			idx_s1      <= idx_in;
			we_s1       <= in_range;
			done_s1     <= done_in;
			fwd_s1      <= fwd_n;
			fwd_data_s1 <= result_s1;
		end
	end

	// advance the frame phase as the last Cr sample leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (adv_s1 && done_s1) begin
			phase_q <= (phase_inc >= cfg.blur_period) ? '0 : phase_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= result_s1;
			out_last_q <= done_s1;
			out_err_q  <= !we_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	rfb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_LUMA_PIXELS)
	) u_luma_ram (
		.clk   (clk),
		.we    (wr_s1 && (plane_s1 == PLANE_LUMA)),
		.waddr (LA'(idx_s1)),
		.wdata (result_s1),
		.re    (accept && (plane_in == PLANE_LUMA)),
		.raddr (LA'(idx_in)),
		.rdata (luma_rdata)
	);

	rfb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (CHROMA_DEPTH)
	) u_cb_ram (
		.clk   (clk),
		.we    (wr_s1 && (plane_s1 == PLANE_CB)),
		.waddr (CA'(idx_s1)),
		.wdata (result_s1),
		.re    (accept && (plane_in == PLANE_CB)),
		.raddr (CA'(idx_in)),
		.rdata (cb_rdata)
	);

	rfb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (CHROMA_DEPTH)
	) u_cr_ram (
		.clk   (clk),
		.we    (wr_s1 && (plane_s1 == PLANE_CR)),
		.waddr (CA'(idx_s1)),
		.wdata (result_s1),
		.re    (accept && (plane_in == PLANE_CR)),
		.raddr (CA'(idx_in)),
		.rdata (cr_rdata)
	);

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking bench for recursive_frame_blur_top: frame-structured sample streams under
// several register settings, with random gaps on both sides and a blur predictor in SV.
// Depends on rfb_pkg and the RTL under sv/.
`default_nettype none
module tb;
	import rfb_pkg::*;

	localparam logic [PLANE_BITS-1:0] PLANE_NONE = 2'd3;
	localparam int unsigned LUMA_DEPTH   = DEFAULT_MAX_LUMA_PIXELS;
	localparam int unsigned CHROMA_DEPTH = DEFAULT_MAX_LUMA_PIXELS / 4;
	localparam int unsigned INDEX_TOP    = (1 << INDEX_BITS) - 1;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int LONG_HOLD       = 300;
	localparam int MAX_REPORTS     = 10;
	localparam int ITEM_TARGET     = 1450;
	localparam int FULL_RASTER_MAX = 256;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic [PLANE_BITS-1:0]  plane;
		logic [INDEX_BITS-1:0]  idx;
	} sample_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic                   done;
		logic                   err;
	} blur_res_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata   = '0;  // sample_value, pixel_index
	logic [PLANE_BITS-1:0]    s_tuser   = '0;  // plane
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [SAMPLE_BITS-1:0]   m_tdata;         // blurred_value
	logic                     m_tlast;         // frame_done
	logic                     m_tuser;         // index_error

	recursive_frame_blur_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// blur predictor state and its copy of the registers
	logic [PERIOD_BITS-1:0] cur_period = RESET_BLUR_PERIOD;
	logic [DIM_BITS-1:0]    cur_width  = RESET_LUMA_WIDTH;
	logic [DIM_BITS-1:0]    cur_height = RESET_LUMA_HEIGHT;
	logic [PERIOD_BITS-1:0] cur_phase  = '0;
	logic [SAMPLE_BITS-1:0] history_mem [int];

	sample_t   sample_q[$];
	blur_res_t blend_exp_q[$];
	int        written_keys[$];
	bit        written_seen [int];

	int pushed_cnt   = 0;
	int accepted_cnt = 0;
	int fail_cnt     = 0;
	int gap_left     = 0;
	int hold_left    = 0;
	int cyc          = 0;
	bit hold_req     = 1'b0;
	bit s_took       = 1'b0;
	bit quiet_src    = 1'b0;
	bit quiet_snk    = 1'b0;

	// usable span of a plane: configured size capped by the store depth
	function automatic int unsigned plane_span(logic [PLANE_BITS-1:0] pl);
		int unsigned llen;
		llen = 32'(cur_width) * 32'(cur_height);
		if (pl == PLANE_LUMA)
			return (llen < LUMA_DEPTH) ? llen : LUMA_DEPTH;
		return (llen / 4 < CHROMA_DEPTH) ? llen / 4 : CHROMA_DEPTH;
	endfunction

	function automatic int unsigned frame_end_idx();
		int unsigned clen;
		clen = (32'(cur_width) * 32'(cur_height)) / 4;
		return (clen == 0) ? 0 : clen - 1;
	endfunction

	function automatic blur_res_t blend_sample(sample_t s);
		blur_res_t              r;
		int                     key;
		logic [SAMPLE_BITS:0]   sum;
		logic [SAMPLE_BITS-1:0] old;
		r.value = s.value;
		r.done  = 1'b0;
		r.err   = 1'b0;
		if (s.plane == PLANE_NONE) begin
			r.err = 1'b1;
			return r;
		end
		if (s.idx >= plane_span(s.plane)) begin
			r.err = 1'b1;
		end else begin
			key = {s.plane, s.idx};
			if (cur_phase != 0) begin
				old = history_mem.exists(key) ? history_mem[key] : '0;
				sum = s.value + old;
				r.value = sum[SAMPLE_BITS:1];
			end
			history_mem[key] = r.value;
		end
		// frame end holds even when the index is flagged
		if (s.plane == PLANE_CR && s.idx == frame_end_idx()) begin
			r.done = 1'b1;
			cur_phase = cur_phase + 1'b1;
			if (cur_phase >= cur_period)
				cur_phase = '0;
		end
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sender
	always @(negedge clk) begin : source
		sample_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_took) begin
			s_took = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				nxt = sample_q.pop_front();
				s_tdata  <= {{(IN_DATA_BITS - INDEX_BITS - SAMPLE_BITS){1'b0}}, nxt.idx, nxt.value};
				s_tuser  <= nxt.plane;
				s_tvalid <= 1'b1;
				gap_left = quiet_src ? 0 : draw_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin : sink
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			stall = quiet_snk ? 0 : draw_gap();
			hold_left = (stall > 0) ? stall - 1 : 0;
			m_tready <= (stall == 0);
		end
	end

	// input side first, so an expectation is queued before its result can be checked
	always @(posedge clk) begin : monitor
		sample_t   got_in;
		blur_res_t got;
		blur_res_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				got_in.value = s_tdata[SAMPLE_BITS-1:0];
				got_in.idx   = s_tdata[SAMPLE_BITS +: INDEX_BITS];
				got_in.plane = s_tuser;
				blend_exp_q.push_back(blend_sample(got_in));
				accepted_cnt++;
				s_took = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.value = m_tdata;
				got.done  = m_tlast;
				got.err   = m_tuser;
				if (blend_exp_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("unexpected transfer: value %0d frame_done %b index_error %b",
							got.value, got.done, got.err);
				end else begin
					want = blend_exp_q.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS) begin
							$write("mismatch: value exp %0d got %0d,", want.value, got.value);
							$display(" frame_done exp %b got %b, index_error exp %b got %b",
								want.done, got.done, want.err, got.err);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc >= CYCLE_LIMIT) begin
			$display("FAIL recursive_frame_blur_top");
			$finish;
		end
	end

	task automatic push_sample(input logic [SAMPLE_BITS-1:0] v, input logic [PLANE_BITS-1:0] pl,
		input logic [INDEX_BITS-1:0] idx, input bit record);
		sample_t s;
		int      key;
		s.value = v;
		s.plane = pl;
		s.idx   = idx;
		sample_q.push_back(s);
		pushed_cnt++;
		key = {pl, idx};
		// remember entries a copy frame writes, so later frames only read written ones
		if (record && pl != PLANE_NONE && idx < plane_span(pl) && !written_seen.exists(key)) begin
			written_seen[key] = 1'b1;
			written_keys.push_back(key);
		end
	endtask

	task automatic push_noise();
		int                    key;
		int unsigned           span;
		logic [PLANE_BITS-1:0] pl;
		case ($urandom_range(0, 2))
			0: begin
				push_sample($urandom_range(0, 255), PLANE_NONE, $urandom_range(0, INDEX_TOP), 0);
			end
			1: begin
				pl = $urandom_range(0, 2);
				span = plane_span(pl);
				if (span <= INDEX_TOP)
					push_sample($urandom_range(0, 255), pl, $urandom_range(span, INDEX_TOP), 0);
				else
					push_sample($urandom_range(0, 255), PLANE_NONE, $urandom_range(0, INDEX_TOP), 0);
			end
			default: begin
				key = written_keys[$urandom_range(0, written_keys.size() - 1)];
				push_sample($urandom_range(0, 255), key[21:20], key[19:0], 0);
			end
		endcase
	endtask

	// first frame after a size change runs at phase zero and writes the entries later frames blend
	task automatic copy_frame();
		int unsigned lspan;
		int unsigned cspan;
		int unsigned ende;
		int unsigned i;
		lspan = plane_span(PLANE_LUMA);
		cspan = plane_span(PLANE_CB);
		ende  = frame_end_idx();
		if (lspan <= FULL_RASTER_MAX) begin
			for (int k = 0; k < lspan; k++)
				push_sample($urandom_range(0, 255), PLANE_LUMA, k, 1);
			for (int k = 0; k < cspan; k++)
				push_sample($urandom_range(0, 255), PLANE_CB, k, 1);
			for (int k = 0; k < cspan; k++)
				if (k != ende)
					push_sample($urandom_range(0, 255), PLANE_CR, k, 1);
		end else begin
			push_sample($urandom_range(0, 255), PLANE_LUMA, 0, 1);
			push_sample($urandom_range(0, 255), PLANE_LUMA, lspan - 1, 1);
			repeat (10)
				push_sample($urandom_range(0, 255), PLANE_LUMA, $urandom_range(0, lspan - 1), 1);
			if (cspan > 0) begin
				push_sample($urandom_range(0, 255), PLANE_CB, 0, 1);
				push_sample($urandom_range(0, 255), PLANE_CB, cspan - 1, 1);
				repeat (5)
					push_sample($urandom_range(0, 255), PLANE_CB, $urandom_range(0, cspan - 1), 1);
				push_sample($urandom_range(0, 255), PLANE_CR, 0, 1);
				repeat (5) begin
					i = $urandom_range(0, cspan - 1);
					if (i != ende)
						push_sample($urandom_range(0, 255), PLANE_CR, i, 1);
				end
			end
		end
		push_sample($urandom_range(0, 255), PLANE_CR, ende, 1);
	endtask

	// frames over the written entries, with dropped samples, noise and missing ends
	task automatic blend_frames(input int n);
		int unsigned           ende;
		int                    key;
		logic [PLANE_BITS-1:0] pl;
		logic [INDEX_BITS-1:0] idx;
		ende = frame_end_idx();
		repeat (n) begin
			foreach (written_keys[k]) begin
				key = written_keys[k];
				pl  = key[21:20];
				idx = key[19:0];
				if (!(pl == PLANE_CR && idx == ende) && $urandom_range(0, 99) < 88)
					push_sample($urandom_range(0, 255), pl, idx, 0);
				if ($urandom_range(0, 99) < 4)
					push_noise();
			end
			if ($urandom_range(0, 99) < 94)
				push_sample($urandom_range(0, 255), PLANE_CR, ende, 0);
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (accepted_cnt != pushed_cnt || blend_exp_q.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] ri, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ri;
		cfg_wdata <= val[CFG_DATA_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (ri)
			REG_BLUR_PERIOD: cur_period = val[PERIOD_BITS-1:0];
			REG_LUMA_WIDTH:  cur_width  = val[DIM_BITS-1:0];
			REG_LUMA_HEIGHT: cur_height = val[DIM_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic run_config(input int period, input int w, input int h, input int nframes);
		// force phase zero with one frame end at period 1, so the new sizes start with a copy
		write_reg(REG_BLUR_PERIOD, 1);
		push_sample($urandom_range(0, 255), PLANE_CR, frame_end_idx(), 0);
		wait_idle();
		write_reg(REG_LUMA_WIDTH, w);
		write_reg(REG_LUMA_HEIGHT, h);
		write_reg(REG_BLUR_PERIOD, period);
		written_keys.delete();
		written_seen.delete();
		quiet_src = ($urandom_range(0, 3) == 0);
		quiet_snk = ($urandom_range(0, 3) == 0);
		copy_frame();
		blend_frames(nframes - 1);
		wait_idle();
	endtask

	initial begin : stim
		int per;
		int wid;
		int hgt;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: copy frame with range edges and flagged samples
		push_sample(8'd255, PLANE_LUMA, 0, 1);
		push_sample(8'd0, PLANE_LUMA, plane_span(PLANE_LUMA) - 1, 1);
		push_sample(8'd9, PLANE_LUMA, plane_span(PLANE_LUMA), 1);
		push_sample(8'd17, PLANE_LUMA, INDEX_TOP, 1);
		push_sample(8'd33, PLANE_NONE, 20'hAAAAA, 1);
		push_sample(8'd200, PLANE_CB, 0, 1);
		push_sample(8'd1, PLANE_CB, plane_span(PLANE_CB) - 1, 1);
		push_sample(8'd5, PLANE_CB, plane_span(PLANE_CB), 1);
		push_sample(8'd128, PLANE_CR, 0, 1);
		push_sample(8'd77, PLANE_CR, frame_end_idx(), 1);
		// blended frame
		push_sample(8'd0, PLANE_LUMA, 0, 0);
		push_sample(8'd255, PLANE_LUMA, plane_span(PLANE_LUMA) - 1, 0);
		push_sample(8'd255, PLANE_CB, 0, 0);
		push_sample(8'd0, PLANE_CR, 0, 0);
		push_sample(8'd255, PLANE_NONE, 20'h55555, 0);
		push_sample(8'd100, PLANE_CR, frame_end_idx(), 0);

		blend_frames(5);
		hold_req = 1'b1;
		blend_frames(2);
		wait_idle();

		run_config(4, 8, 4, 8);
		run_config(1000, 2048, 2048, 5);
		run_config(0, 1, 1, 12);
		run_config(1000, 6, 6, 6);
		// lower the period below the current phase
		write_reg(REG_BLUR_PERIOD, 2);
		blend_frames(3);
		wait_idle();
		run_config(1, 2048, 1, 3);
		run_config(3, 1, 2048, 3);

		while (pushed_cnt < ITEM_TARGET) begin
			per = ($urandom_range(0, 9) == 0) ? 1000 : $urandom_range(0, 6);
			wid = $urandom_range(1, 8);
			hgt = $urandom_range(1, 8);
			if ($urandom_range(0, 7) == 0)
				wid = $urandom_range(1, 2048);
			run_config(per, wid, hgt, $urandom_range(2, 3));
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && blend_exp_q.size() == 0)
			$display("PASS recursive_frame_blur_top");
		else
			$display("FAIL recursive_frame_blur_top");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
sv/rfb_pkg.sv
sv/rfb_ram.sv
sv/rfb_cfg.sv
sv/recursive_frame_blur_top.sv
sim/tb.sv
